/* sv/ahfr_pkg.sv */
// Package: shared types, character codes and hex decoding for the frame receiver.
`default_nettype none

package ahfr_pkg;

  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_N     = 8'h4e;
  localparam logic [7:0] CH_O     = 8'h4f;
  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_K     = 8'h4b;
  localparam logic [7:0] CH_EQ    = 8'h3d;

  localparam logic [5:0] EXPECTED_LENGTH_RESET = 6'd23;

  // Frame offsets kept for decoding: keyword at 6..9, payload at 10..17.
  localparam int FIELD_FIRST = 6;
  localparam int FIELD_COUNT = 12;

  typedef enum logic [2:0] {
    ST_INPUTS    = 3'd0,
    ST_OUT_ECHO  = 3'd1,
    ST_WRITE_OK  = 3'd2,
    ST_UNKNOWN   = 3'd3,
    ST_LENGTH    = 3'd4,
    ST_CHECKSUM  = 3'd5,
    ST_OVERFLOW  = 3'd6
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] input_bits;
    logic [63:0] out_echo_text;
    logic [5:0]  frame_length;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } beat_t;

  // Bit 4 set when c is not a hex digit; low nibble holds the digit value.
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] v;
    case (c) inside
      [8'h30:8'h39]: v = {1'b0, 4'(c - 8'h30)};
      [8'h41:8'h46]: v = {1'b0, 4'(c - 8'h37)};
      [8'h61:8'h66]: v = {1'b0, 4'(c - 8'h57)};
      default:       v = 5'h10;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* sv/ahfr_if.sv */
// Interfaces: received byte channel and frame result channel.
`default_nettype none

interface ahfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ahfr_result_if;
  logic               valid;
  logic               ready;
  ahfr_pkg::status_t  status;
  logic [31:0]        input_bits;
  logic [63:0]        out_echo_text;
  logic [5:0]         frame_length;

  modport source (output valid, output status, output input_bits,
                  output out_echo_text, output frame_length, input ready);
  modport sink (input valid, input status, input input_bits,
                input out_echo_text, input frame_length, output ready);
endinterface

`default_nettype wire

/* sv/ascii_hex_frame_receiver.sv */
// Top level: ASCII hex frame receiver with input and result registers.
//
//   channel      dir  handshake       payload
//   byte_in      in   valid/ready     rx_byte[7:0]
//   result_out   out  valid/ready     status, input_bits, out_echo_text, frame_length
//   cfg          in   cfg_write       cfg_data[5:0] (expected_length)
//
// One byte per cycle sustained while the result register is free; a result is presented
// once the byte that closes the frame has passed the input register, then the result register.
// Synchronous reset closes any frame, clears the checksum and sets the
// expected length to 23. A stalled result holds the parser; the input
// register still takes one more byte.
`default_nettype none

module ascii_hex_frame_receiver #(
  parameter int MAX_FRAME = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [5:0] cfg_data,
  ahfr_byte_if.sink       byte_in,
  ahfr_result_if.source   result_out
);

  ahfr_pkg::beat_t   held;
  ahfr_pkg::result_t res;
  logic              res_valid;
  logic              free;
  logic              take;

  assign take = held.valid && free;

  ahfr_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .take    (take),
    .held    (held)
  );

  ahfr_parser #(
    .MAX_FRAME (MAX_FRAME)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .step      (take),
    .rx_byte   (held.data),
    .res_valid (res_valid),
    .res       (res)
  );

  ahfr_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (res_valid),
    .res        (res),
    .free       (free),
    .result_out (result_out)
  );

endmodule

`default_nettype wire

/* sv/ahfr_in_reg.sv */
// Input register: holds one received byte until the parser takes it.
`default_nettype none

module ahfr_in_reg (
  input  wire logic    clk,
  input  wire logic    rst,
  ahfr_byte_if.sink    byte_in,
  input  wire logic    take,
  output ahfr_pkg::beat_t held
);

  logic       valid;
  logic [7:0] data;

  assign byte_in.ready = !valid || take;
  assign held.valid    = valid;
  assign held.data     = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (byte_in.valid && byte_in.ready) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_in.valid && byte_in.ready) begin
      data <= byte_in.rx_byte;
    end
  end

endmodule

`default_nettype wire

/* sv/ahfr_parser.sv */
// Frame parser: frame state, tail detection, checksum and payload decode.
`default_nettype none

module ahfr_parser #(
  parameter int MAX_FRAME = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [5:0] cfg_data,
  input  wire logic       step,
  input  wire logic [7:0] rx_byte,
  output logic            res_valid,
  output ahfr_pkg::result_t res
);

  localparam int CW   = $clog2(MAX_FRAME + 1);
  localparam int CMPW = (CW > 6) ? CW : 6;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [7:0]    running_xor;
  logic [7:0]    running_xor_next;
  logic [5:0]    expected_length;
  logic [7:0]    field [ahfr_pkg::FIELD_COUNT];
  logic [7:0]    hist [4];

  logic [CW-1:0] n;
  logic          store;
  logic [7:0]    fb [ahfr_pkg::FIELD_COUNT];
  logic [4:0]    hi;
  logic [4:0]    lo;
  logic [4:0]    dh;
  logic [4:0]    dl;
  logic [7:0]    cks;
  logic          tail;

  always_comb begin
    n                = count + 1'b1;
    store            = 1'b0;
    count_next       = count;
    running_xor_next = running_xor;
    res_valid        = 1'b0;
    dh               = '0;
    dl               = '0;
    res.status        = ahfr_pkg::ST_UNKNOWN;
    res.input_bits    = '0;
    res.out_echo_text = '0;
    res.frame_length  = 6'(n);

    for (int j = 0; j < ahfr_pkg::FIELD_COUNT; j++) begin
      if (CMPW'(ahfr_pkg::FIELD_FIRST + j) < CMPW'(count)) begin
        fb[j] = field[j];
      end else if (CMPW'(ahfr_pkg::FIELD_FIRST + j) == CMPW'(count)) begin
        fb[j] = rx_byte;
      end else begin
        fb[j] = 8'h00;
      end
    end

    hi  = ahfr_pkg::hex_val(hist[2]);
    lo  = ahfr_pkg::hex_val(hist[1]);
    cks = running_xor ^ rx_byte ^ hist[2] ^ hist[1] ^ ahfr_pkg::CH_CR ^ ahfr_pkg::CH_LF;
    tail = (CMPW'(n) >= CMPW'(6)) && hist[3] == ahfr_pkg::CH_HASH &&
           hist[0] == ahfr_pkg::CH_CR && rx_byte == ahfr_pkg::CH_LF;

    if (count == '0) begin
      if (rx_byte == ahfr_pkg::CH_START) begin
        count_next       = CW'(1);
        running_xor_next = rx_byte;
      end
    end else if (rx_byte == 8'h00) begin
      count_next       = '0;
      running_xor_next = 8'h00;
    end else if (CMPW'(count) >= CMPW'(MAX_FRAME)) begin
      count_next       = '0;
      running_xor_next = 8'h00;
      res_valid        = 1'b1;
      res.status       = ahfr_pkg::ST_OVERFLOW;
      res.frame_length = 6'(count);
    end else begin
      store            = 1'b1;
      count_next       = n;
      running_xor_next = running_xor ^ rx_byte;
      if (tail) begin
        count_next       = '0;
        running_xor_next = 8'h00;
        res_valid        = 1'b1;
        if (CMPW'(n) != CMPW'(expected_length)) begin
          res.status = ahfr_pkg::ST_LENGTH;
        end else if (hi[4] || lo[4] || {hi[3:0], lo[3:0]} != cks) begin
          res.status = ahfr_pkg::ST_CHECKSUM;
        end else if (fb[0] == ahfr_pkg::CH_D && fb[1] == ahfr_pkg::CH_I &&
                     fb[2] == ahfr_pkg::CH_N && fb[3] == ahfr_pkg::CH_EQ) begin
          res.status = ahfr_pkg::ST_INPUTS;
          for (int k = 0; k < 4; k++) begin
            dh = ahfr_pkg::hex_val(fb[4 + 2 * k]);
            dl = ahfr_pkg::hex_val(fb[5 + 2 * k]);
            res.input_bits[8*k +: 8] = {dh[4] ? 4'h0 : dh[3:0], dl[4] ? 4'h0 : dl[3:0]};
          end
        end else if (fb[0] == ahfr_pkg::CH_O && fb[1] == ahfr_pkg::CH_U &&
                     fb[2] == ahfr_pkg::CH_T && fb[3] == ahfr_pkg::CH_EQ) begin
          res.status = ahfr_pkg::ST_OUT_ECHO;
          for (int k = 0; k < 8; k++) begin
            res.out_echo_text[8*k +: 8] = fb[4 + k];
          end
        end else if (fb[0] == ahfr_pkg::CH_O && fb[1] == ahfr_pkg::CH_K) begin
          res.status = ahfr_pkg::ST_WRITE_OK;
        end else begin
          res.status = ahfr_pkg::ST_UNKNOWN;
        end
      end
    end
    if (!step) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count           <= '0;
      running_xor     <= 8'h00;
      expected_length <= ahfr_pkg::EXPECTED_LENGTH_RESET;
    end else begin
      if (cfg_write) begin
        expected_length <= cfg_data;
      end
      if (step) begin
        count       <= count_next;
        running_xor <= running_xor_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && store) begin
      hist[0] <= rx_byte;
      hist[1] <= hist[0];
      hist[2] <= hist[1];
      hist[3] <= hist[2];
      for (int j = 0; j < ahfr_pkg::FIELD_COUNT; j++) begin
        if (CMPW'(count) == CMPW'(ahfr_pkg::FIELD_FIRST + j)) begin
          field[j] <= rx_byte;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* sv/ahfr_out_reg.sv */
// Result register: holds one frame result until the sink takes it.
`default_nettype none

module ahfr_out_reg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire ahfr_pkg::result_t res,
  output logic                   free,
  ahfr_result_if.source          result_out
);

  logic              valid;
  ahfr_pkg::result_t data;

  assign free                     = !valid || result_out.ready;
  assign result_out.valid         = valid;
  assign result_out.status        = data.status;
  assign result_out.input_bits    = data.input_bits;
  assign result_out.out_echo_text = data.out_echo_text;
  assign result_out.frame_length  = data.frame_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (result_out.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

endmodule

`default_nettype wire
